// ===== rtl/lobm_pkg.sv =====
// Package for the limit order book matcher: sizes, result codes, sequencer states,
// search-unit structs and small slot/address helpers.
// No dependencies.
package lobm_pkg;

    localparam int PRICE_TICKS      = 256;
    localparam int LEVEL_DEPTH      = 8;
    localparam int MAX_SWEEP_TRADES = 63;

    localparam int QTY_W   = 16;
    localparam int PX_W    = 8;
    localparam int PRICE_W = $clog2(PRICE_TICKS);
    localparam int HEAD_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
    localparam int META_W  = CNT_W + HEAD_W;
    localparam int QDEPTH  = PRICE_TICKS * LEVEL_DEPTH;
    localparam int QA_W    = $clog2(QDEPTH);
    localparam int N_W     = $clog2(MAX_SWEEP_TRADES + 1);
    localparam int CMP_W   = (PRICE_W > PX_W) ? PRICE_W : PX_W;
    localparam int LO_W    = PRICE_W / 2;
    localparam int HI_W    = PRICE_W - LO_W;

    // result codes
    typedef enum logic [2:0] {
        K_MATCHED  = 3'd0,
        K_RESTED   = 3'd1,
        K_REJECTED = 3'd2,
        K_TRADE    = 3'd3,
        K_DONE     = 3'd4,
        K_CAPPED   = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_SRCH,
        ST_A_SWAIT,
        ST_A_XRD,
        ST_A_XQRD,
        ST_A_XUPD,
        ST_A_ORD,
        ST_A_OCHK,
        ST_W_SB,
        ST_W_SBW,
        ST_W_SA,
        ST_W_SAW,
        ST_W_MRD,
        ST_W_QRD,
        ST_W_EXE,
        ST_PUSH
    } state_t;

    // per-level bookkeeping word
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [HEAD_W-1:0] head;
    } meta_t;

    typedef struct packed {
        logic start;
        logic find_max;
    } srch_req_t;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [PRICE_W-1:0] idx;
    } srch_res_t;

    function automatic logic [QA_W-1:0] qaddr(input logic [PRICE_W-1:0] price,
                                              input logic [HEAD_W-1:0] slot);
        return QA_W'(price) * QA_W'(LEVEL_DEPTH) + QA_W'(slot);
    endfunction

    // (head + count) mod depth, both below depth
    function automatic logic [HEAD_W-1:0] slot_after(input logic [HEAD_W-1:0] head,
                                                     input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(cnt);
        if (s >= (CNT_W+1)'(LEVEL_DEPTH))
        begin
            s = s - (CNT_W+1)'(LEVEL_DEPTH);
        end
        return HEAD_W'(s);
    endfunction

    function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] head);
        logic [HEAD_W-1:0] r;
        if (head == HEAD_W'(LEVEL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = head + HEAD_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/lobm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lobm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lobm_search.sv =====
// Best-level finder: two registered stages (group, then level in group) over an
// occupancy vector. Lowest set level or highest set level. Uses lobm_pkg.
module lobm_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lobm_pkg::srch_req_t           req,
    input  logic [lobm_pkg::PRICE_TICKS-1:0] occ,
    output lobm_pkg::srch_res_t           res
);
    import lobm_pkg::*;

    localparam int POW = 1 << PRICE_W;
    localparam int NG  = 1 << HI_W;
    localparam int GS  = 1 << LO_W;

    logic [POW-1:0]     occ_pad;
    logic [NG-1:0]      grp_any;
    logic [HI_W-1:0]    grp_pick;
    logic [GS-1:0]      sub;
    logic [LO_W-1:0]    sub_pick;

    logic               s1_reg;
    logic               max_reg;
    logic               gfound_reg;
    logic [HI_W-1:0]    grp_reg;
    logic               done_reg;
    logic               found_reg;
    logic [PRICE_W-1:0] idx_reg;

    assign occ_pad = POW'(occ);

    // stage 1: which group holds the best level
    always_comb
    begin
        grp_pick = '0;
        for (int g = 0; g < NG; g++)
        begin
            grp_any[g] = |occ_pad[g*GS +: GS];
        end
        if (req.find_max)
        begin
            for (int g = 0; g < NG; g++)
            begin
                if (grp_any[g])
                begin
                    grp_pick = HI_W'(g);
                end
            end
        end
        else
        begin
            for (int g = NG - 1; g >= 0; g--)
            begin
                if (grp_any[g])
                begin
                    grp_pick = HI_W'(g);
                end
            end
        end
    end

    // stage 2: best level inside the chosen group
    always_comb
    begin
        sub      = occ_pad[{grp_reg, {LO_W{1'b0}}} +: GS];
        sub_pick = '0;
        if (max_reg)
        begin
            for (int j = 0; j < GS; j++)
            begin
                if (sub[j])
                begin
                    sub_pick = LO_W'(j);
                end
            end
        end
        else
        begin
            for (int j = GS - 1; j >= 0; j--)
            begin
                if (sub[j])
                begin
                    sub_pick = LO_W'(j);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= req.start;
            done_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            max_reg    <= req.find_max;
            grp_reg    <= grp_pick;
            gfound_reg <= |grp_any;
        end
        if (s1_reg)
        begin
            found_reg <= gfound_reg;
            idx_reg   <= PRICE_W'({grp_reg, sub_pick});
        end
    end

    assign res.done  = done_reg;
    assign res.found = found_reg;
    assign res.idx   = idx_reg;

endmodule

// ===== rtl/limit_order_book_matcher_core.sv =====
// Limit order book matcher with price-time priority per level.
// Uses lobm_pkg, lobm_ram (quantity and level stores) and lobm_search.
//
// One request at a time; in_stall stays high from acceptance until the last result
// of the request has been placed in the output register. An add runs the two-stage
// best-level search once, then reads the opposite level and quantity if it crosses,
// else its own level to rest or reject it (a zero quantity or a price beyond the
// book rejects it without that read). A sweep runs the search once per side for each
// step and reads the level and quantity RAMs, registered, for each trade. Each result
// may wait while out_stall holds the output register full.
// No clearing pass after reset: empty levels are tracked by occupancy flip-flops.
module limit_order_book_matcher_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic                         side,
    input  logic [lobm_pkg::PX_W-1:0]    limit_price,
    input  logic [lobm_pkg::QTY_W-1:0]   order_qty,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   kind,
    output logic [lobm_pkg::QTY_W-1:0]   fill_qty,
    output logic [lobm_pkg::PX_W-1:0]    fill_price,
    output logic                         last
);
    import lobm_pkg::*;

    state_t st_reg, st_next;
    state_t ret_reg, ret_next;

    logic               side_reg;
    logic [PX_W-1:0]    lp_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [PRICE_W-1:0] opp_reg, b_reg, a_reg;
    logic               bf_reg;
    logic [N_W-1:0]     n_reg;
    meta_t              bmeta_reg, ameta_reg;

    kind_t              res_kind_reg;
    logic [QTY_W-1:0]   res_qty_reg;
    logic [PX_W-1:0]    res_price_reg;
    logic               res_last_reg;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [QTY_W-1:0]   out_qty_reg;
    logic [PX_W-1:0]    out_price_reg;
    logic               out_last_reg;

    logic [PRICE_TICKS-1:0] occ_bid_reg, occ_ask_reg;
    logic [PRICE_W-1:0]     bm_ridx_reg, am_ridx_reg;

    srch_req_t srq;
    srch_res_t srs;
    logic      srch_bid;

    // memory ports
    logic [PRICE_W-1:0] bm_raddr, am_raddr, bm_waddr, am_waddr;
    logic               bm_we, am_we;
    meta_t              bm_wdata, am_wdata;
    logic [META_W-1:0]  bm_rdata, am_rdata;
    meta_t              bm_eff, am_eff, own;
    logic [QA_W-1:0]    bq_raddr, aq_raddr, bq_waddr, aq_waddr;
    logic               bq_we, aq_we;
    logic [QTY_W-1:0]   bq_wdata, aq_wdata, bq_rd, aq_rd;

    logic               accept, push_ok;
    logic [PRICE_W-1:0] lp_idx;
    logic               crosses, add_rej, full, no_cross;
    logic [QTY_W-1:0]   trade, bq_left, aq_left;

    assign accept  = in_valid && !in_stall;
    assign push_ok = !out_valid_reg || !out_stall;
    assign lp_idx  = PRICE_W'(lp_reg);

    // masked level reads: an empty level reads as count 0, head 0
    assign bm_eff = occ_bid_reg[bm_ridx_reg] ? meta_t'(bm_rdata) : '0;
    assign am_eff = occ_ask_reg[am_ridx_reg] ? meta_t'(am_rdata) : '0;
    assign own    = side_reg ? am_eff : bm_eff;
    assign full   = own.cnt >= CNT_W'(LEVEL_DEPTH);

    // decisions taken when the search result comes back
    always_comb
    begin
        if (side_reg)
        begin
            crosses = srs.found && (CMP_W'(srs.idx) >= CMP_W'(lp_reg));
        end
        else
        begin
            crosses = srs.found && (CMP_W'(srs.idx) <= CMP_W'(lp_reg));
        end
        add_rej  = (qty_reg == '0) || (int'(lp_reg) >= PRICE_TICKS);
        no_cross = !bf_reg || !srs.found || (b_reg < srs.idx);
    end

    // trade unit
    assign trade   = (bq_rd < aq_rd) ? bq_rd : aq_rd;
    assign bq_left = bq_rd - trade;
    assign aq_left = aq_rd - trade;

    // next state
    always_comb
    begin
        st_next  = st_reg;
        ret_next = ret_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    st_next = req_type ? ST_W_SB : ST_A_SRCH;
                end
            end
            ST_A_SRCH:  st_next = ST_A_SWAIT;
            ST_A_SWAIT:
            begin
                if (srs.done)
                begin
                    if (crosses)
                    begin
                        st_next = ST_A_XRD;
                    end
                    else if (add_rej)
                    begin
                        st_next  = ST_PUSH;
                        ret_next = ST_IDLE;
                    end
                    else
                    begin
                        st_next = ST_A_ORD;
                    end
                end
            end
            ST_A_XRD:   st_next = ST_A_XQRD;
            ST_A_XQRD:  st_next = ST_A_XUPD;
            ST_A_XUPD,
            ST_A_OCHK:
            begin
                st_next  = ST_PUSH;
                ret_next = ST_IDLE;
            end
            ST_A_ORD:   st_next = ST_A_OCHK;
            ST_W_SB:    st_next = ST_W_SBW;
            ST_W_SBW:
            begin
                if (srs.done)
                begin
                    st_next = ST_W_SA;
                end
            end
            ST_W_SA:    st_next = ST_W_SAW;
            ST_W_SAW:
            begin
                if (srs.done)
                begin
                    if (no_cross || (n_reg == N_W'(MAX_SWEEP_TRADES)))
                    begin
                        st_next  = ST_PUSH;
                        ret_next = ST_IDLE;
                    end
                    else
                    begin
                        st_next = ST_W_MRD;
                    end
                end
            end
            ST_W_MRD:   st_next = ST_W_QRD;
            ST_W_QRD:   st_next = ST_W_EXE;
            ST_W_EXE:
            begin
                st_next  = ST_PUSH;
                ret_next = ST_W_SB;
            end
            ST_PUSH:
            begin
                if (push_ok)
                begin
                    st_next = ret_reg;
                end
            end
            default:    st_next = ST_IDLE;
        endcase
    end

    // outputs: search requests and memory ports
    always_comb
    begin
        in_stall     = (st_reg != ST_IDLE);
        srq.start    = (st_reg == ST_A_SRCH) || (st_reg == ST_W_SB) || (st_reg == ST_W_SA);
        srq.find_max = (st_reg == ST_W_SB) || ((st_reg == ST_A_SRCH) && side_reg);
        // bid occupancy feeds both search stages of a bid search
        srch_bid     = (st_reg == ST_W_SB) || (st_reg == ST_W_SBW)
                       || (side_reg && ((st_reg == ST_A_SRCH) || (st_reg == ST_A_SWAIT)));

        bm_raddr = (st_reg == ST_W_MRD) ? b_reg : ((st_reg == ST_A_XRD) ? opp_reg : lp_idx);
        am_raddr = (st_reg == ST_W_MRD) ? a_reg : ((st_reg == ST_A_XRD) ? opp_reg : lp_idx);
        bq_raddr = qaddr((st_reg == ST_W_QRD) ? b_reg : opp_reg, bm_eff.head);
        aq_raddr = qaddr((st_reg == ST_W_QRD) ? a_reg : opp_reg, am_eff.head);

        bm_we    = 1'b0;
        am_we    = 1'b0;
        bm_waddr = lp_idx;
        am_waddr = lp_idx;
        bm_wdata = '0;
        am_wdata = '0;
        bq_we    = 1'b0;
        aq_we    = 1'b0;
        bq_waddr = qaddr(lp_idx, slot_after(own.head, own.cnt));
        aq_waddr = qaddr(lp_idx, slot_after(own.head, own.cnt));
        bq_wdata = qty_reg;
        aq_wdata = qty_reg;

        case (st_reg)
            ST_A_XUPD:
            begin
                // pop the crossing head on the opposite side
                bm_waddr = opp_reg;
                am_waddr = opp_reg;
                bm_wdata = '{cnt: bmeta_reg.cnt - CNT_W'(1), head: head_inc(bmeta_reg.head)};
                am_wdata = '{cnt: ameta_reg.cnt - CNT_W'(1), head: head_inc(ameta_reg.head)};
                bm_we    = side_reg;
                am_we    = !side_reg;
            end
            ST_A_OCHK:
            begin
                // append to the tail of the own level
                bm_wdata = '{cnt: own.cnt + CNT_W'(1), head: own.head};
                am_wdata = '{cnt: own.cnt + CNT_W'(1), head: own.head};
                bm_we    = !full && !side_reg;
                am_we    = !full && side_reg;
                bq_we    = !full && !side_reg;
                aq_we    = !full && side_reg;
            end
            ST_W_EXE:
            begin
                // both heads lose the trade size; empty heads are popped
                bq_we    = 1'b1;
                aq_we    = 1'b1;
                bq_waddr = qaddr(b_reg, bmeta_reg.head);
                aq_waddr = qaddr(a_reg, ameta_reg.head);
                bq_wdata = bq_left;
                aq_wdata = aq_left;
                bm_waddr = b_reg;
                am_waddr = a_reg;
                bm_wdata = '{cnt: bmeta_reg.cnt - CNT_W'(1), head: head_inc(bmeta_reg.head)};
                am_wdata = '{cnt: ameta_reg.cnt - CNT_W'(1), head: head_inc(ameta_reg.head)};
                bm_we    = (bq_left == '0);
                am_we    = (aq_left == '0);
            end
            default:
            begin
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            out_valid_reg <= 1'b0;
            occ_bid_reg   <= '0;
            occ_ask_reg   <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            ret_reg <= ret_next;
            if (st_reg == ST_PUSH && push_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (bm_we)
            begin
                occ_bid_reg[bm_waddr] <= (bm_wdata.cnt != '0);
            end
            if (am_we)
            begin
                occ_ask_reg[am_waddr] <= (am_wdata.cnt != '0);
            end
        end
    end

    // request fields, search results and pending result
    always_ff @(posedge clk)
    begin
        bm_ridx_reg <= bm_raddr;
        am_ridx_reg <= am_raddr;
        if (accept)
        begin
            side_reg <= side;
            lp_reg   <= limit_price;
            qty_reg  <= order_qty;
            n_reg    <= '0;
        end
        if (st_reg == ST_A_SWAIT && srs.done)
        begin
            opp_reg       <= srs.idx;
            res_kind_reg  <= crosses ? K_MATCHED : K_REJECTED;
            res_qty_reg   <= '0;
            res_price_reg <= crosses ? PX_W'(srs.idx) : lp_reg;
            res_last_reg  <= 1'b1;
        end
        if (st_reg == ST_W_SBW && srs.done)
        begin
            bf_reg <= srs.found;
            b_reg  <= srs.idx;
        end
        if (st_reg == ST_W_SAW && srs.done)
        begin
            a_reg         <= srs.idx;
            res_kind_reg  <= no_cross ? K_DONE : K_CAPPED;
            res_qty_reg   <= '0;
            res_price_reg <= '0;
            res_last_reg  <= 1'b1;
        end
        if (st_reg == ST_A_XQRD || st_reg == ST_W_QRD)
        begin
            bmeta_reg <= bm_eff;
            ameta_reg <= am_eff;
        end
        if (st_reg == ST_A_XUPD)
        begin
            res_qty_reg <= side_reg ? bq_rd : aq_rd;
        end
        if (st_reg == ST_A_OCHK)
        begin
            res_kind_reg <= full ? K_REJECTED : K_RESTED;
        end
        if (st_reg == ST_W_EXE)
        begin
            res_kind_reg  <= K_TRADE;
            res_qty_reg   <= trade;
            res_price_reg <= PX_W'(a_reg);
            res_last_reg  <= 1'b0;
            n_reg         <= n_reg + N_W'(1);
        end
        if (st_reg == ST_PUSH && push_ok)
        begin
            out_kind_reg  <= res_kind_reg;
            out_qty_reg   <= res_qty_reg;
            out_price_reg <= res_price_reg;
            out_last_reg  <= res_last_reg;
        end
    end

    lobm_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (srq),
        .occ   (srch_bid ? occ_bid_reg : occ_ask_reg),
        .res   (srs)
    );

    lobm_ram #(.WIDTH(META_W), .DEPTH(PRICE_TICKS)) u_bid_meta (
        .clk (clk), .we (bm_we), .waddr (bm_waddr), .wdata (META_W'(bm_wdata)),
        .raddr (bm_raddr), .rdata (bm_rdata)
    );

    lobm_ram #(.WIDTH(META_W), .DEPTH(PRICE_TICKS)) u_ask_meta (
        .clk (clk), .we (am_we), .waddr (am_waddr), .wdata (META_W'(am_wdata)),
        .raddr (am_raddr), .rdata (am_rdata)
    );

    lobm_ram #(.WIDTH(QTY_W), .DEPTH(QDEPTH)) u_bid_qty (
        .clk (clk), .we (bq_we), .waddr (bq_waddr), .wdata (bq_wdata),
        .raddr (bq_raddr), .rdata (bq_rd)
    );

    lobm_ram #(.WIDTH(QTY_W), .DEPTH(QDEPTH)) u_ask_qty (
        .clk (clk), .we (aq_we), .waddr (aq_waddr), .wdata (aq_wdata),
        .raddr (aq_raddr), .rdata (aq_rd)
    );

    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign fill_qty   = out_qty_reg;
    assign fill_price = out_price_reg;
    assign last       = out_last_reg;

endmodule

// ===== tb/limit_order_book_matcher_checker.sv =====
// Checker for the limit order book matcher: watches both channels, keeps its own
// copy of the book, predicts each request's results and compares them in order.
// Depends on lobm_pkg.
module limit_order_book_matcher_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         req_type,
    input  logic                         side,
    input  logic [lobm_pkg::PX_W-1:0]    limit_price,
    input  logic [lobm_pkg::QTY_W-1:0]   order_qty,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [2:0]                   kind,
    input  logic [lobm_pkg::QTY_W-1:0]   fill_qty,
    input  logic [lobm_pkg::PX_W-1:0]    fill_price,
    input  logic                         last,
    output int                           fail_count,
    output int                           pending_count,
    output int                           trade_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lobm_pkg::*;

    typedef struct packed {
        kind_t           k;
        logic [QTY_W-1:0] qty;
        logic [PX_W-1:0]  px;
        logic            lst;
    } book_result_t;

    book_result_t expected_results[$];

    // book model: index [side][price], side 0 bid, 1 ask
    logic [QTY_W-1:0] level_qty [2][PRICE_TICKS][LEVEL_DEPTH];
    int               level_cnt [2][PRICE_TICKS];
    int               level_head[2][PRICE_TICKS];

    function automatic int best_level(input int s);
        int p;
        if (s == 1)
        begin
            for (p = 0; p < PRICE_TICKS; p++)
                if (level_cnt[1][p] != 0) return p;
        end
        else
        begin
            for (p = PRICE_TICKS - 1; p >= 0; p--)
                if (level_cnt[0][p] != 0) return p;
        end
        return -1;
    endfunction

    task automatic push_result(input kind_t k, input int q, input int p, input bit l);
        book_result_t r;
        r.k = k;
        r.qty = QTY_W'(q);
        r.px = PX_W'(p);
        r.lst = l;
        expected_results.push_back(r);
    endtask

    task automatic pop_level(input int s, input int p);
        level_head[s][p] = (level_head[s][p] + 1) % LEVEL_DEPTH;
        level_cnt[s][p]--;
    endtask

    // predict results of one accepted request
    task automatic predict_book(input bit rt, input bit sd, input int lp, input int q);
        int opp, own, n, b, a, t;
        bit crosses;
        logic [QTY_W-1:0] bq, aq;
        if (!rt)
        begin
            own = sd ? 1 : 0;
            opp = best_level(sd ? 0 : 1);
            crosses = (opp >= 0) && (sd ? (opp >= lp) : (opp <= lp));
            if (crosses)
            begin
                push_result(K_MATCHED,
                    level_qty[1-own][opp][level_head[1-own][opp]], opp, 1);
                pop_level(1 - own, opp);
            end
            else if (q == 0 || lp >= PRICE_TICKS || level_cnt[own][lp] >= LEVEL_DEPTH)
                push_result(K_REJECTED, 0, lp, 1);
            else
            begin
                level_qty[own][lp][(level_head[own][lp] + level_cnt[own][lp])
                    % LEVEL_DEPTH] = QTY_W'(q);
                level_cnt[own][lp]++;
                push_result(K_RESTED, 0, lp, 1);
            end
        end
        else
        begin
            n = 0;
            forever
            begin
                b = best_level(0);
                a = best_level(1);
                if (b < 0 || a < 0 || b < a)
                begin
                    push_result(K_DONE, 0, 0, 1);
                    break;
                end
                if (n >= MAX_SWEEP_TRADES)
                begin
                    push_result(K_CAPPED, 0, 0, 1);
                    break;
                end
                bq = level_qty[0][b][level_head[0][b]];
                aq = level_qty[1][a][level_head[1][a]];
                t = (bq < aq) ? bq : aq;
                push_result(K_TRADE, t, a, 0);
                n++;
                trade_count++;
                level_qty[0][b][level_head[0][b]] = bq - QTY_W'(t);
                level_qty[1][a][level_head[1][a]] = aq - QTY_W'(t);
                if (bq == QTY_W'(t)) pop_level(0, b);
                if (aq == QTY_W'(t)) pop_level(1, a);
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        trade_count = 0;
        pending_count = 0;
        for (int s = 0; s < 2; s++)
            for (int p = 0; p < PRICE_TICKS; p++)
            begin
                level_cnt[s][p] = 0;
                level_head[s][p] = 0;
            end
    end

    // request side predicts, result side compares
    always @(posedge clk)
    begin
        book_result_t e;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_book(req_type, side, int'(limit_price), int'(order_qty));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d qty=%0d px=%0d last=%0d",
                             $time, kind, fill_qty, fill_price, last);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (kind !== e.k || fill_qty !== e.qty || fill_price !== e.px
                        || last !== e.lst)
                    begin
                        $display("%0t: mismatch expected kind=%0d qty=%0d px=%0d last=%0d",
                                 $time, e.k, e.qty, e.px, e.lst);
                        $display("%0t:          actual   kind=%0d qty=%0d px=%0d last=%0d",
                                 $time, kind, fill_qty, fill_price, last);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end
endmodule

// ===== tb/limit_order_book_matcher_core_test.sv =====
// Top of the order book matcher testbench: clock, reset, request stimulus and
// result-side stalls. Uses lobm_pkg, limit_order_book_matcher_core and the checker.
module limit_order_book_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lobm_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic               side;
    logic [PX_W-1:0]    limit_price;
    logic [QTY_W-1:0]   order_qty;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         kind;
    logic [QTY_W-1:0]   fill_qty;
    logic [PX_W-1:0]    fill_price;
    logic               last;
    int                 fail_count;
    int                 pending_count;
    int                 trade_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 sent_count;
    bit                 hold_off;

    limit_order_book_matcher_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .side(side), .limit_price(limit_price),
        .order_qty(order_qty),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .fill_qty(fill_qty), .fill_price(fill_price), .last(last)
    );

    limit_order_book_matcher_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // send one request; valid stays high until accepted, called at a falling edge
    task automatic send_request(input bit rt, input bit sd, input int lp, input int q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        side <= sd;
        limit_price <= PX_W'(lp);
        order_qty <= QTY_W'(q);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // mostly prices near the middle so levels fill and cross
    task automatic send_random;
        int pick;
        int lp;
        int q;
        pick = $urandom_range(99);
        lp = ($urandom_range(9) == 0) ? $urandom_range(255) : 120 + $urandom_range(15);
        q = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 50);
        if ($urandom_range(19) == 0) q = 0;
        if (pick < 15)
            send_request(1'b1, 1'($urandom), $urandom_range(255), $urandom_range(65535));
        else
            send_request(1'b0, 1'($urandom), lp, q);
    endtask

    // result side stalls; a long hold-off while the sender keeps offering
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        side = 1'b0;
        limit_price = '0;
        order_qty = '0;
        out_stall = 1'b1;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent_count = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty sweep, rejects, rest, full level, crosses, sweeps
        send_request(1'b1, 1'b0, 0, 0);
        send_request(1'b0, 1'b0, 10, 0);
        send_request(1'b0, 1'b0, 255, 65535);
        send_request(1'b0, 1'b1, 0, 1);
        for (int i = 0; i < 9; i++)
            send_request(1'b0, 1'b0, 100, 65535 - i);
        send_request(1'b0, 1'b1, 100, 0);
        send_request(1'b0, 1'b1, 50, 7);
        send_request(1'b0, 1'b0, 200, 3);
        send_request(1'b0, 1'b1, 255, 65535);
        send_request(1'b0, 1'b0, 255, 0);
        send_request(1'b0, 1'b1, 0, 0);
        send_request(1'b1, 1'b1, 255, 65535);
        send_request(1'b0, 1'b1, 200, 5);
        send_request(1'b1, 1'b0, 0, 0);

        // deep book: many small asks, bids that take them, then sweeps
        for (int i = 0; i < 8; i++)
            send_request(1'b0, 1'b0, 30, 60000);
        for (int p = 0; p < 8; p++)
            for (int i = 0; i < 8; i++)
                send_request(1'b0, 1'b1, 200 + p, 1);
        for (int p = 0; p < 8; p++)
            send_request(1'b0, 1'b0, 220, 1);
        send_request(1'b1, 1'b0, 0, 0);
        send_request(1'b1, 1'b0, 0, 0);

        // random phases with different idle mixes
        send_idle_pct = 21;
        recv_idle_pct = 76;
        repeat (60) send_random();
        send_idle_pct = 76;
        recv_idle_pct = 21;
        repeat (55) send_random();

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            repeat (6) send_random();
        join
        repeat (35) send_random();
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d requests, predicted %0d sweep trades.", sent_count, trade_count);
        $display("Covered rests, rejects, crosses, full levels, sweeps and output back-pressure.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
